### src/modbus_reply_frame_hunter_defines.svh
// Assertion macros shared by the frame hunter modules.
`ifndef MODBUS_REPLY_FRAME_HUNTER_DEFINES_SVH
`define MODBUS_REPLY_FRAME_HUNTER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define MRFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define MRFH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/mrfh_pkg.sv
// Shared types, constants and functions of the Modbus reply frame hunter.
package mrfh_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned CRC_BYTES   = FRAME_BYTES - 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SLAVE_ID_RESET   = 8'h01;
  localparam logic [7:0] FUNCTION_RESET   = 8'h03;
  localparam logic [7:0] BYTE_COUNT_RESET = 8'h04;

  // Division by ten through a reciprocal, exact for every 16-bit dividend.
  localparam logic [15:0] DIV10_MULT  = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam logic [15:0] TEN         = 16'd10;

  typedef logic [3:0] fill_t;
  typedef logic [2:0] crc_idx_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ID   = 2'd0,
    CFG_FUNCTION   = 2'd1,
    CFG_BYTE_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CRC,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic rx_ready;
    logic load_byte;
    logic drop;
    logic crc_init;
    logic crc_step;
    logic load_div;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic header_ok;
    logic crc_last;
    logic crc_ok;
    logic out_busy;
  } dp_status_t;

  // One byte of the reflected CRC-16/MODBUS update.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/mrfh_if.sv
// Valid/ready channel interfaces for received bytes and decoded frames.
interface mrfh_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfh_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_raw;
  logic [12:0] speed_whole;
  logic [3:0]  speed_tenths;
  logic [15:0] direction;

  modport source (output valid, output speed_raw, output speed_whole,
                  output speed_tenths, output direction, input ready);
  modport sink   (input valid, input speed_raw, input speed_whole,
                  input speed_tenths, input direction, output ready);
endinterface

### src/modbus_reply_frame_hunter.sv
// Top level of the Modbus RTU reply frame hunter.
//
// Bytes from the serial receiver arrive one per beat on rx_i. The block keeps
// the last nine bytes; once nine are held it checks slave id, function code and
// byte count against the configuration registers, then runs a CRC-16/MODBUS
// pass over bytes zero to six, one byte per cycle, and compares it with the
// trailing two bytes (low byte first). A good frame produces one beat on res_o
// carrying speed (bytes three and four), speed split into whole and tenths, and
// direction (bytes five and six); the window is then emptied. A failed check
// drops the oldest byte. Each byte is stored while the controller is idle and
// then evaluated; a full window with a good header goes on through the CRC
// pass, the check, the divide state and the emit state. One byte is processed
// at a time: rx_i.ready is high only while the controller is idle. The result
// sits in an output register, so the next byte is taken while a result waits;
// if the receiver still stalls when the following frame is ready, that frame
// holds until the result is taken.
// Reset empties the window, drops any pending result and restores the register
// values 1, 3 and 4. Registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; index 3 is ignored.
module modbus_reply_frame_hunter
  import mrfh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  mrfh_rx_if.sink    rx_i,
  mrfh_res_if.source res_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Ready to the byte source comes straight from the controller.
  assign rx_i.ready = cmd.rx_ready;

  mrfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrfh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .rx_byte_i      (rx_i.rx_byte),
    .cmd_i          (cmd),
    .status_o       (status),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .speed_raw_o    (res_o.speed_raw),
    .speed_whole_o  (res_o.speed_whole),
    .speed_tenths_o (res_o.speed_tenths),
    .direction_o    (res_o.direction)
  );

endmodule

### src/mrfh_datapath.sv
// Byte window, configuration registers, CRC unit, divider and result register.
`include "modbus_reply_frame_hunter_defines.svh"

module mrfh_datapath
  import mrfh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [7:0]  rx_byte_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output logic [15:0] speed_raw_o,
  output logic [12:0] speed_whole_o,
  output logic [3:0]  speed_tenths_o,
  output logic [15:0] direction_o
);

  logic [7:0]  win_q [FRAME_BYTES];
  fill_t       fill_q;
  logic [7:0]  slave_id_q, function_q, byte_count_q;
  logic [15:0] crc_q;
  crc_idx_t    idx_q;
  logic [15:0] speed_q;
  logic [31:0] prod_q;
  logic        out_valid_q;
  logic [15:0] speed_raw_q, direction_q;
  logic [12:0] speed_whole_q;
  logic [3:0]  speed_tenths_q;

  logic [7:0]  crc_byte_in;
  logic [12:0] quot;
  logic [15:0] rem_full;

  assign crc_byte_in = win_q[{1'b0, idx_q}];
  assign quot        = prod_q[31:DIV10_SHIFT];
  assign rem_full    = speed_q - 16'({quot, 3'b000} + {3'b000, quot, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q   <= SLAVE_ID_RESET;
      function_q   <= FUNCTION_RESET;
      byte_count_q <= BYTE_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ID:   slave_id_q   <= cfg_data_i;
        CFG_FUNCTION:   function_q   <= cfg_data_i;
        CFG_BYTE_COUNT: byte_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A full window on a new byte shifts out the oldest byte first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.load_byte) begin
      if (fill_q == fill_t'(FRAME_BYTES)) begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          win_q[i] <= win_q[i + 1];
        end
        win_q[FRAME_BYTES - 1] <= rx_byte_i;
      end else begin
        win_q[fill_q] <= rx_byte_i;
        fill_q        <= fill_q + fill_t'(1);
      end
    end else if (cmd_i.drop) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[FRAME_BYTES - 1] <= '0;
      fill_q                 <= fill_q - fill_t'(1);
    end else if (cmd_i.emit) begin
      fill_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      idx_q <= '0;
    end else if (cmd_i.crc_init) begin
      crc_q <= CRC_INIT;
      idx_q <= '0;
    end else if (cmd_i.crc_step) begin
      crc_q <= crc_byte(crc_q, crc_byte_in);
      idx_q <= idx_q + crc_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      speed_q <= {win_q[3], win_q[4]};
      prod_q  <= {win_q[3], win_q[4]} * DIV10_MULT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      speed_raw_q    <= speed_q;
      speed_whole_q  <= quot;
      speed_tenths_q <= rem_full[3:0];
      direction_q    <= {win_q[5], win_q[6]};
    end
  end

  assign status_o.full      = (fill_q == fill_t'(FRAME_BYTES));
  assign status_o.header_ok = (win_q[0] == slave_id_q) && (win_q[1] == function_q)
                              && (win_q[2] == byte_count_q);
  assign status_o.crc_last  = (idx_q == crc_idx_t'(CRC_BYTES - 1));
  assign status_o.crc_ok    = (win_q[FRAME_BYTES - 2] == crc_q[7:0])
                              && (win_q[FRAME_BYTES - 1] == crc_q[15:8]);
  assign status_o.out_busy  = out_valid_q && !res_ready_i;

  assign res_valid_o    = out_valid_q;
  assign speed_raw_o    = speed_raw_q;
  assign speed_whole_o  = speed_whole_q;
  assign speed_tenths_o = speed_tenths_q;
  assign direction_o    = direction_q;

  `MRFH_ASSERT_NEVER(a_fill_range, fill_q > fill_t'(FRAME_BYTES), "fill count above frame size")
  `MRFH_ASSERT(a_emit_full, cmd_i.emit |-> fill_q == fill_t'(FRAME_BYTES), "emit without full window")
  `MRFH_ASSERT(a_crc_idx, cmd_i.crc_step |-> idx_q < crc_idx_t'(CRC_BYTES), "CRC index past data bytes")

endmodule

### src/mrfh_ctrl.sv
// Controller state machine sequencing store, header test, CRC pass and output.
`include "modbus_reply_frame_hunter_defines.svh"

module mrfh_ctrl
  import mrfh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rx_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.full && status_i.header_ok) state_d = ST_CRC;
        else state_d = ST_IDLE;
      end
      ST_CRC: begin
        if (status_i.crc_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.crc_ok ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.rx_ready  = 1'b1;
        cmd_o.load_byte = rx_valid_i;
      end
      ST_EVAL: begin
        cmd_o.drop     = status_i.full && !status_i.header_ok;
        cmd_o.crc_init = status_i.full && status_i.header_ok;
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.load_div = status_i.crc_ok;
        cmd_o.drop     = !status_i.crc_ok;
      end
      ST_DIV: ;
      ST_EMIT: begin
        cmd_o.emit = !status_i.out_busy;
      end
      default: ;
    endcase
  end

  `MRFH_ASSERT(a_crc_exit, state_q == ST_CRC |=> state_q == ST_CRC || state_q == ST_CHECK, "bad exit from CRC pass")
  `MRFH_ASSERT(a_div_emit, state_q == ST_DIV |=> state_q == ST_EMIT, "divide not followed by emit")
  `MRFH_ASSERT(a_one_cmd, $onehot0({cmd_o.load_byte, cmd_o.drop, cmd_o.emit}), "conflicting window commands")

endmodule
